>>> src/fsp_pkg.sv
// shared types and constants of the fixed rate send pacer
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int TIME_W     = 63;
    localparam int SEQ_W      = 32;
    localparam int BYTES_W    = 16;
    localparam int RATE_W     = 40;
    localparam int CFG_W      = 32;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = BYTES_W + 1;
    // (65535 + 42) * 1e9 stays below 2^46, times eight below 2^49
    localparam int PROD_W     = 46;
    localparam int NUM_W      = PROD_W + 3;

    localparam logic [29:0]       NS_PER_SEC     = 30'd1000000000;
    localparam logic [LEN_W-1:0]  OVERHEAD_BYTES = 17'd42;

    localparam logic [RATE_W-1:0] RATE_RESET  = 40'd1000000;
    localparam logic [CFG_W-1:0]  TOL_RESET   = 32'd1000000;
    localparam logic [CFG_W-1:0]  QUIET_RESET = 32'd10000000;

    typedef enum logic [1:0] {
        REQ_CONNECT = 2'd0,
        REQ_SEND    = 2'd1,
        REQ_RESEND  = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE  = 2'd0,
        CFG_TOL   = 2'd1,
        CFG_QUIET = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [CFG_W-1:0]  tol;
        logic [CFG_W-1:0]  quiet;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/fixed_rate_send_pacer.sv
// top level of the fixed rate send pacer
`timescale 1ns / 1ps
`default_nettype none

// Send pacer for a fixed bit rate, all times in nanoseconds. One request is
// taken at a time and gives one result beat. A connect and a timed-out
// resend go straight to the result and a query passes the tolerance compare;
// for a send or a paced resend the inter-send gap floor(8e9 * (bytes + 42) /
// rate) comes from a shared restoring divider that yields one of 49 quotient
// bits per cycle, followed by the restart compare and the saturating add onto
// the next send time. The result sits in an output register, so the next
// request is taken while an earlier result still waits. Configuration writes
// are always taken; a rate write of zero is ignored.
module fixed_rate_send_pacer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [fsp_pkg::TIME_W-1:0]      now_ns,
    input  logic [fsp_pkg::BYTES_W-1:0]     total_bytes,
    input  logic                            rto_resend,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fsp_pkg::SEQ_W-1:0]       seq_out,
    output logic [fsp_pkg::TIME_W-1:0]      wait_ns,
    output logic                            can_send,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fsp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_BASE,
        S_ADD,
        S_QUERY,
        S_FIN
    } state_t;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    cfg_t cfg;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TIME_W-1:0]   base_reg, base_next;
    logic [TIME_W:0]     diff_reg, diff_next;
    logic [TIME_W-1:0]   next_send_reg, next_send_next;
    logic [SEQ_W-1:0]    seq_cnt_reg, seq_cnt_next;
    logic                connected_reg, connected_next;
    logic [SEQ_W-1:0]    seq_res_reg, seq_res_next;
    logic [TIME_W-1:0]   wait_res_reg, wait_res_next;
    logic                out_valid_reg, out_valid_next;
    logic [SEQ_W-1:0]    seq_out_reg, seq_out_next;
    logic [TIME_W-1:0]   wait_out_reg, wait_out_next;
    logic                can_out_reg, can_out_next;

    logic                accept;
    logic [LEN_W-1:0]    len;
    logic [PROD_W:0]     prod_full;
    logic [TIME_W:0]     limit;
    logic [TIME_W:0]     sum;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [NUM_W-1:0]    gap;

    fsp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (RATE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({prod_reg, 3'b000}),
        .den   (cfg.rate),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (gap)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign div_start = (state_reg == S_DIV_GO);

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        bytes_next     = bytes_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        diff_next      = diff_reg;
        next_send_next = next_send_reg;
        seq_cnt_next   = seq_cnt_reg;
        connected_next = connected_reg;
        seq_res_next   = seq_res_reg;
        wait_res_next  = wait_res_reg;
        out_valid_next = out_valid_reg;
        seq_out_next   = seq_out_reg;
        wait_out_next  = wait_out_reg;
        can_out_next   = can_out_reg;

        len       = {1'b0, bytes_reg} + OVERHEAD_BYTES;
        prod_full = (PROD_W + 1)'(len) * (PROD_W + 1)'(NS_PER_SEC);
        limit     = {1'b0, next_send_reg} + (TIME_W + 1)'(cfg.quiet);
        sum       = {1'b0, base_reg} + (TIME_W + 1)'(gap);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next      = now_ns;
                    bytes_next    = total_bytes;
                    seq_res_next  = '0;
                    wait_res_next = '0;
                    case (req_t'(req_type))
                        REQ_CONNECT:
                        begin
                            connected_next = 1'b1;
                            state_next     = S_FIN;
                        end
                        REQ_SEND:
                        begin
                            seq_res_next = seq_cnt_reg;
                            seq_cnt_next = seq_cnt_reg + 1'b1;
                            state_next   = S_MUL;
                        end
                        REQ_RESEND:
                        begin
                            state_next = rto_resend ? S_FIN : S_MUL;
                        end
                        REQ_QUERY:
                        begin
                            diff_next  = {1'b0, next_send_reg} - {1'b0, now_ns};
                            state_next = S_QUERY;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = prod_full[PROD_W-1:0];
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                // restart pacing from the packet time after a quiet spell
                if ({1'b0, now_reg} > limit)
                begin
                    base_next = now_reg;
                end
                else
                begin
                    base_next = next_send_reg;
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                next_send_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                state_next     = S_FIN;
            end
            S_QUERY:
            begin
                // next - now above the tolerance means now + tol is still short
                if (!diff_reg[TIME_W] && (diff_reg[TIME_W-1:0] > TIME_W'(cfg.tol)))
                begin
                    wait_res_next = diff_reg[TIME_W-1:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    seq_out_next   = seq_res_reg;
                    wait_out_next  = wait_res_reg;
                    can_out_next   = connected_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            bytes_reg     <= '0;
            prod_reg      <= '0;
            base_reg      <= '0;
            diff_reg      <= '0;
            next_send_reg <= '0;
            seq_cnt_reg   <= '0;
            connected_reg <= 1'b0;
            seq_res_reg   <= '0;
            wait_res_reg  <= '0;
            out_valid_reg <= 1'b0;
            seq_out_reg   <= '0;
            wait_out_reg  <= '0;
            can_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            bytes_reg     <= bytes_next;
            prod_reg      <= prod_next;
            base_reg      <= base_next;
            diff_reg      <= diff_next;
            next_send_reg <= next_send_next;
            seq_cnt_reg   <= seq_cnt_next;
            connected_reg <= connected_next;
            seq_res_reg   <= seq_res_next;
            wait_res_reg  <= wait_res_next;
            out_valid_reg <= out_valid_next;
            seq_out_reg   <= seq_out_next;
            wait_out_reg  <= wait_out_next;
            can_out_reg   <= can_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign seq_out   = seq_out_reg;
    assign wait_ns   = wait_out_reg;
    assign can_send  = can_out_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("divider busy while a new request can be taken");

    a_next_send_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ADD) |=> $stable(next_send_reg))
        else $error("next send time changed outside the add step");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_SEND)) |=> (seq_cnt_reg == $past(seq_cnt_reg) + 1'b1))
        else $error("sequence counter did not advance on a send");

    a_connected_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        connected_reg |=> connected_reg)
        else $error("connected flag dropped");

endmodule

`default_nettype wire

>>> src/fsp_cfg.sv
// configuration registers of the send pacer
`timescale 1ns / 1ps
`default_nettype none

module fsp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]   wr_data,
    output fsp_pkg::cfg_t                    cfg
);
    import fsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_RATE:
                begin
                    // a zero rate is refused
                    if (wr_data[RATE_W-1:0] != '0)
                    begin
                        cfg_next.rate = wr_data[RATE_W-1:0];
                    end
                end
                CFG_TOL:   cfg_next.tol   = wr_data[CFG_W-1:0];
                CFG_QUIET: cfg_next.quiet = wr_data[CFG_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate  <= RATE_RESET;
            cfg_reg.tol   <= TOL_RESET;
            cfg_reg.quiet <= QUIET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/fsp_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module fsp_div #(
    parameter int NUM_W = fsp_pkg::NUM_W,
    parameter int DEN_W = fsp_pkg::RATE_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import fsp_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // numerator bits leave at the top while quotient bits enter below
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W-1:0];
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
            end
            quot_next = {quot_reg[NUM_W-2:0], ~trial[DEN_W+1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            den_reg  <= den_next;
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == LAST);
    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> sim/fixed_rate_send_pacer_check.sv
// checker for the send pacer: predicts every result beat and compares it
`timescale 1ns / 1ps

module fixed_rate_send_pacer_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [fsp_pkg::TIME_W-1:0]        now_ns,
    input  logic [fsp_pkg::BYTES_W-1:0]       total_bytes,
    input  logic                              rto_resend,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [fsp_pkg::SEQ_W-1:0]         seq_out,
    input  logic [fsp_pkg::TIME_W-1:0]        wait_ns,
    input  logic                              can_send,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                errors,
    output int                                outstanding
);
    import fsp_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    // one byte at one bit per second, in ns
    localparam logic [63:0]       BYTE_TIME_NS = 64'd8000000000;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] wait_time;
        logic              connected;
    } pacer_beat_t;

    logic [RATE_W-1:0] rate_bps;
    logic [CFG_W-1:0]  tol_ns;
    logic [CFG_W-1:0]  quiet_ns;
    logic [TIME_W-1:0] next_send;
    logic [SEQ_W-1:0]  seq_count;
    logic              connected;

    pacer_beat_t due_beats[$];

    // next send time after a paced packet at time t
    function automatic logic [TIME_W-1:0] paced_time(logic [TIME_W-1:0] t,
                                                     logic [BYTES_W-1:0] nbytes);
        logic [63:0] gap;
        logic [63:0] base;
        logic [63:0] sum;
        gap  = BYTE_TIME_NS * (64'(nbytes) + 64'(OVERHEAD_BYTES)) / 64'(rate_bps);
        base = (64'(t) > 64'(next_send) + 64'(quiet_ns)) ? 64'(t) : 64'(next_send);
        sum  = base + gap;
        return (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic pacer_beat_t pace_request(logic [1:0] req, logic [TIME_W-1:0] t,
                                                 logic [BYTES_W-1:0] nbytes, logic rto);
        pacer_beat_t beat;
        beat = '0;
        case (req)
            REQ_CONNECT: connected = 1'b1;
            REQ_SEND:
            begin
                beat.seq  = seq_count;
                seq_count = seq_count + 1'b1;
                next_send = paced_time(t, nbytes);
            end
            REQ_RESEND:
            begin
                if (!rto)
                    next_send = paced_time(t, nbytes);
            end
            REQ_QUERY:
            begin
                if (64'(t) + 64'(tol_ns) < 64'(next_send))
                    beat.wait_time = next_send - t;
            end
            default: ;
        endcase
        beat.connected = connected;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pacer_beat_t got;
        pacer_beat_t want;
        if (!rst_n)
        begin
            rate_bps    = RATE_RESET;
            tol_ns      = TOL_RESET;
            quiet_ns    = QUIET_RESET;
            next_send   = '0;
            seq_count   = '0;
            connected   = 1'b0;
            due_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RATE:
                    begin
                        if (cfg_data[RATE_W-1:0] != '0)
                            rate_bps = cfg_data[RATE_W-1:0];
                    end
                    CFG_TOL:   tol_ns   = cfg_data[CFG_W-1:0];
                    CFG_QUIET: quiet_ns = cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{seq_out, wait_ns, can_send};
                if (due_beats.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat with none expected: %s %0d %0d %0b",
                                 $realtime, "seq/wait/can_send", seq_out, wait_ns,
                                 can_send);
                    errors <= errors + 1;
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (got.seq !== want.seq || got.wait_time !== want.wait_time ||
                        got.connected !== want.connected)
                    begin
                        if (errors < 10)
                            $display({"%0t: result mismatch: seq %0d/%0d wait %0d/%0d",
                                      " can_send %0b/%0b (exp/got)"},
                                     $realtime, want.seq, got.seq, want.wait_time,
                                     got.wait_time, want.connected, got.connected);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                due_beats.push_back(pace_request(req_type, now_ns, total_bytes, rto_resend));
            outstanding <= due_beats.size();
        end
    end

endmodule

>>> sim/fixed_rate_send_pacer_test.sv
// testbench top: stimulus, idling, watchdog and verdict for the send pacer
`timescale 1ns / 1ps

module fixed_rate_send_pacer_test;

    import fsp_pkg::*;

    localparam int                HOLD_CYCLES = 400;
    localparam int                IDLE_LIMIT  = 4000;
    localparam int                TAIL_CYCLES = 64;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [1:0]        CFG_SPARE   = 2'd3;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type    = REQ_CONNECT;
    logic [TIME_W-1:0]     now_ns      = '0;
    logic [BYTES_W-1:0]    total_bytes = '0;
    logic                  rto_resend  = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [SEQ_W-1:0]      seq_out;
    logic [TIME_W-1:0]     wait_ns;
    logic                  can_send;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_RATE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int                    errors;
    int                    outstanding;
    int                    idle_cycles = 0;
    bit                    hold_off_req = 1'b0;
    bit                    steady       = 1'b0;
    logic [TIME_W-1:0]     clock_ns     = '0;

    fixed_rate_send_pacer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .now_ns      (now_ns),
        .total_bytes (total_bytes),
        .rto_resend  (rto_resend),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .seq_out     (seq_out),
        .wait_ns     (wait_ns),
        .can_send    (can_send),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    fixed_rate_send_pacer_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .now_ns      (now_ns),
        .total_bytes (total_bytes),
        .rto_resend  (rto_resend),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .seq_out     (seq_out),
        .wait_ns     (wait_ns),
        .can_send    (can_send),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly no gap, some short, a few long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 120);
    endfunction

    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_gap();
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // leaves valid high on return so a following beat can go straight out
    task automatic offer(logic [1:0] req, logic [TIME_W-1:0] t, logic [BYTES_W-1:0] nbytes,
                         logic rto);
        in_valid    <= 1'b1;
        req_type    <= req;
        now_ns      <= t;
        total_bytes <= nbytes;
        rto_resend  <= rto;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [RATE_W-1:0] rate, logic [CFG_W-1:0] tol,
                             logic [CFG_W-1:0] quiet);
        drain();
        write_reg(CFG_RATE, rate);
        // upper bits of the narrow registers are noise
        write_reg(CFG_TOL, {8'($urandom), tol});
        write_reg(CFG_QUIET, {8'($urandom), quiet});
        cfg_valid <= 1'b0;
    endtask

    // a connect, then a random mix; time mostly creeps forward by about step
    task automatic run_phase(logic [TIME_W-1:0] step, int count);
        int                 pick;
        int                 pause;
        logic [1:0]         req;
        logic [BYTES_W-1:0] nbytes;
        offer(REQ_CONNECT, clock_ns, 16'($urandom), 1'($urandom));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                clock_ns = clock_ns + TIME_W'((64'(step) * $urandom_range(0, 1024)) >> 9);
            else if (pick < 80)
                clock_ns = clock_ns + TIME_W'(64'(step) * $urandom_range(2, 20));
            else if (pick < 88)
                clock_ns = clock_ns - TIME_W'(64'(step) * $urandom_range(0, 4));
            else if (pick < 95)
                clock_ns = TIME_W'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 5)
                req = REQ_CONNECT;
            else if (pick < 45)
                req = REQ_SEND;
            else if (pick < 65)
                req = REQ_RESEND;
            else
                req = REQ_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                nbytes = BYTES_W'($urandom_range(0, 1500));
            else if (pick < 85)
                nbytes = BYTES_W'($urandom);
            else
                nbytes = (pick < 92) ? '0 : '1;
            offer(req, clock_ns, nbytes, 1'($urandom));
            pause = idle_gap();
            if (pause != 0)
            begin
                in_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [RATE_W-1:0] rate;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // from reset: next send time 0, rate 1 Mbit/s, 1 ms tolerance, 10 ms idle
        offer(REQ_QUERY, '0, '0, 1'b0);
        offer(REQ_CONNECT, '1, '1, 1'b1);
        offer(REQ_SEND, '0, '0, 1'b0);
        offer(REQ_QUERY, '0, '0, 1'b0);
        offer(REQ_SEND, '0, '1, 1'b0);
        offer(REQ_QUERY, '0, '0, 1'b0);
        // query right on the tolerance edge, then one ns short of it
        offer(REQ_QUERY, 63'd523952000, '0, 1'b0);
        offer(REQ_QUERY, 63'd523951999, '0, 1'b0);
        // timed-out resend leaves pacing alone
        offer(REQ_RESEND, 63'd1000, 16'd100, 1'b1);
        offer(REQ_RESEND, '0, 16'd100, 1'b0);
        // one ns past the idle threshold restarts from now, exactly on it does not
        offer(REQ_SEND, 63'd536088001, '0, 1'b0);
        offer(REQ_SEND, 63'd546424001, '0, 1'b0);
        offer(REQ_QUERY, '0, '0, 1'b0);
        // saturation at the top of the time range
        offer(REQ_SEND, TIME_MAX, '1, 1'b0);
        offer(REQ_QUERY, TIME_MAX, '0, 1'b0);
        offer(REQ_QUERY, '0, '0, 1'b0);
        offer(REQ_CONNECT, '0, '0, 1'b0);
        offer(REQ_RESEND, '0, '0, 1'b0);
        offer(REQ_RESEND, TIME_MAX, '1, 1'b1);

        configure('1, '0, '0);
        clock_ns = '0;
        run_phase(63'd200, 120);

        configure(40'd1, '1, '1);
        run_phase(63'd1000000000000, 80);

        configure(40'd1000000000, 32'd5000, 32'd100000);
        run_phase(63'd2000, 75);
        // receiver holds off while beats keep coming, so the input backs up
        hold_off_req = 1'b1;
        for (int n = 0; n < 12; n++)
        begin
            clock_ns = clock_ns + 63'd1000;
            offer(REQ_SEND, clock_ns, BYTES_W'($urandom_range(0, 1500)), 1'b0);
        end
        run_phase(63'd2000, 63);

        // zero rate is refused, spare index does nothing
        drain();
        write_reg(CFG_RATE, '0);
        write_reg(CFG_SPARE, 40'($urandom));
        write_reg(CFG_TOL, {8'($urandom), 32'($urandom)});
        write_reg(CFG_QUIET, {8'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
        run_phase(63'd2000, 65);
        drain();
        run_phase(63'd2000, 65);

        rate = RATE_W'($urandom_range(100000, 100000000));
        configure(rate, TOL_RESET, QUIET_RESET);
        run_phase(TIME_W'(64'd6400000000000 / 64'(rate)), 130);

        steady = 1'b1;
        configure(RATE_RESET, TOL_RESET, QUIET_RESET);
        run_phase(63'd1500000, 150);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/fsp_pkg.sv
src/fsp_cfg.sv
src/fsp_div.sv
src/fixed_rate_send_pacer.sv
sim/fixed_rate_send_pacer_check.sv
sim/fixed_rate_send_pacer_test.sv
